FILE: hw/rtl/lpb_pkg.sv
// ----------------------------------------------------------------------------
// Layer pixel blender package
// Shared word types, blend mode codes and constants for the layer blender.
// ----------------------------------------------------------------------------
package lpb_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned FUNC_W = 3;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'hFF;

    localparam logic [FUNC_W-1:0] MODE_ADD        = 3'd0;
    localparam logic [FUNC_W-1:0] MODE_SUB        = 3'd1;
    localparam logic [FUNC_W-1:0] MODE_SRC        = 3'd2;
    localparam logic [FUNC_W-1:0] MODE_ZERO       = 3'd3;
    localparam logic [FUNC_W-1:0] MODE_ALPHA_OVER = 3'd4;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t              src_red;
        chan_t              src_green;
        chan_t              src_blue;
        chan_t              src_alpha;
        logic [FUNC_W-1:0]  func;
        logic               last_layer;
    } lpb_in_t;

    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        chan_t out_alpha;
    } lpb_out_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } lpb_stage_ctrl_t;

endpackage

FILE: hw/rtl/lpb_channel_blend.sv
// ----------------------------------------------------------------------------
// Layer pixel blender channel unit
// Blends one source colour channel into one destination channel.
// ----------------------------------------------------------------------------
module lpb_channel_blend
    import lpb_pkg::*;
(
    input  logic [FUNC_W-1:0] func,
    input  chan_t             src,
    input  chan_t             dst,
    input  chan_t             alpha,
    output chan_t             result
);

    logic [CHAN_W:0]     add_sum;
    chan_t               add_res;
    chan_t               sub_res;
    logic [2*CHAN_W-1:0] prod_src;
    logic [2*CHAN_W-1:0] prod_dst;
    logic [2*CHAN_W-1:0] mix_sum;
    logic [2*CHAN_W:0]   div_sum;
    chan_t               over_res;

    assign add_sum = {1'b0, src} + {1'b0, dst};
    assign add_res = add_sum[CHAN_W] ? FULL_SCALE : add_sum[CHAN_W-1:0];
    assign sub_res = (dst > src) ? (dst - src) : '0;

    assign prod_src = src * alpha;
    assign prod_dst = dst * (FULL_SCALE - alpha);
    assign mix_sum  = prod_src + prod_dst;

    // Exact division by 255 for the blend sum, which is at most 255 * 255.
    assign div_sum  = {1'b0, mix_sum} + (2*CHAN_W+1)'(1)
                    + {{(CHAN_W+1){1'b0}}, mix_sum[2*CHAN_W-1:CHAN_W]};
    assign over_res = div_sum[2*CHAN_W-1:CHAN_W];

    always_comb begin
        unique case (func)
            MODE_ADD:        result = add_res;
            MODE_SUB:        result = sub_res;
            MODE_SRC:        result = src;
            MODE_ZERO:       result = '0;
            MODE_ALPHA_OVER: result = over_res;
            default:         result = dst;
        endcase
    end

endmodule

FILE: hw/rtl/lpb_accum_stage.sv
// ----------------------------------------------------------------------------
// Layer pixel blender accumulator stage
// Blends registered layer words into the held pixel; a top layer clears it.
// ----------------------------------------------------------------------------
module lpb_accum_stage
    import lpb_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  lpb_stage_ctrl_t ctrl,
    input  lpb_in_t         layer,
    output lpb_out_t        pixel
);

    chan_t red_reg;
    chan_t green_reg;
    chan_t blue_reg;
    chan_t red_next;
    chan_t green_next;
    chan_t blue_next;
    chan_t red_blend;
    chan_t green_blend;
    chan_t blue_blend;

    lpb_channel_blend u_red (
        .func   (layer.func),
        .src    (layer.src_red),
        .dst    (red_reg),
        .alpha  (layer.src_alpha),
        .result (red_blend)
    );

    lpb_channel_blend u_green (
        .func   (layer.func),
        .src    (layer.src_green),
        .dst    (green_reg),
        .alpha  (layer.src_alpha),
        .result (green_blend)
    );

    lpb_channel_blend u_blue (
        .func   (layer.func),
        .src    (layer.src_blue),
        .dst    (blue_reg),
        .alpha  (layer.src_alpha),
        .result (blue_blend)
    );

    always_comb begin
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (ctrl.valid && ctrl.advance) begin
            if (layer.last_layer) begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end else begin
                red_next   = red_blend;
                green_next = green_blend;
                blue_next  = blue_blend;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end else begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pixel = '{out_red:   red_blend,
                     out_green: green_blend,
                     out_blue:  blue_blend,
                     out_alpha: FULL_SCALE};

endmodule

FILE: hw/rtl/layer_pixel_blender_top.sv
// ----------------------------------------------------------------------------
// Layer pixel blender
// Composites one output pixel from a stack of layer words, bottom layer first.
// ----------------------------------------------------------------------------
// Each word on the s_ channel carries one layer's source pixel, its blend
// mode and a flag marking the top layer. Words enter an input register and
// are blended into an RGB accumulator in the following cycle. A word that is
// not the top layer produces no output; a top-layer word produces one
// composited pixel on the m_ channel, with alpha 255, and clears the
// accumulator for the next pixel.
// A top-layer word reaches m_valid through the input and result registers.
// Throughput is one word per cycle unless a top-layer word waits on m_ready;
// the accumulator loop closes through the blend arithmetic.
// Reset clears the accumulator and both valid flags, so no pixel is pending.
// When the receiver stalls, the result register holds its pixel; words that
// are not top layers still drain into the accumulator, and a top-layer word
// waits in the input register, which then deasserts s_ready.
// ----------------------------------------------------------------------------
module layer_pixel_blender_top
    import lpb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lpb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lpb_out_t m_data
);

    logic            in_valid_reg;
    logic            in_valid_next;
    lpb_in_t         in_data_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    lpb_out_t        out_data_reg;
    lpb_out_t        blended;
    logic            advance;
    lpb_stage_ctrl_t stage_ctrl;

    assign advance = in_valid_reg
                   && (!in_data_reg.last_layer || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign stage_ctrl = '{valid: in_valid_reg, advance: advance};

    lpb_accum_stage u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stage_ctrl),
        .layer   (in_data_reg),
        .pixel   (blended)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_data_reg.last_layer) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_data_reg.last_layer) begin
            out_data_reg <= blended;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("Accepted word did not reach the input register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.last_layer |=> m_valid)
        else $error("Top-layer word did not produce a result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_alpha == FULL_SCALE)
        else $error("Result alpha is not full scale.");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("Valid flags not cleared by reset.");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer pixel blender testbench
// Streams stacks of layer words through the blender and checks every pixel.
// ----------------------------------------------------------------------------
// A short directed set covers each blend mode, saturation and clamping, the
// alpha extremes, the undefined modes and single-layer pixels. A long run of
// random layer stacks follows. Both handshakes idle at random. An in-bench
// model of the accumulator predicts each composited pixel, and every output
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import lpb_pkg::*;

    localparam int RANDOM_WORDS = 1700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 20;

    logic     aclk;
    logic     aresetn;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lpb_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lpb_out_t m_data;

    lpb_in_t  layer_q[$];
    lpb_out_t pixel_q[$];

    chan_t dest_red   = '0;
    chan_t dest_green = '0;
    chan_t dest_blue  = '0;

    int  mismatches = 0;
    int  cycles     = 0;
    int  send_gap   = 0;
    int  recv_gap   = 0;
    bit  send_calm  = 1'b0;
    bit  recv_calm  = 1'b0;

    layer_pixel_blender_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic chan_t blend_chan(logic [FUNC_W-1:0] mode, chan_t s, chan_t d,
                                         chan_t a);
        int unsigned t;
        case (mode)
            MODE_ADD: begin
                t = s + d;
                return (t > FULL_SCALE) ? FULL_SCALE : chan_t'(t);
            end
            MODE_SUB:   return (d > s) ? chan_t'(d - s) : chan_t'(0);
            MODE_SRC:   return s;
            MODE_ZERO:  return chan_t'(0);
            MODE_ALPHA_OVER: begin
                t = s * a + d * (FULL_SCALE - a);
                return chan_t'(t / FULL_SCALE);
            end
            default:    return d;
        endcase
    endfunction

    task automatic predict_layer(lpb_in_t w);
        lpb_out_t px;
        dest_red   = blend_chan(w.func, w.src_red,   dest_red,   w.src_alpha);
        dest_green = blend_chan(w.func, w.src_green, dest_green, w.src_alpha);
        dest_blue  = blend_chan(w.func, w.src_blue,  dest_blue,  w.src_alpha);
        if (w.last_layer) begin
            px.out_red   = dest_red;
            px.out_green = dest_green;
            px.out_blue  = dest_blue;
            px.out_alpha = FULL_SCALE;
            pixel_q.push_back(px);
            dest_red   = '0;
            dest_green = '0;
            dest_blue  = '0;
        end
    endtask

    task automatic queue_layer(chan_t r, chan_t g, chan_t b, chan_t a,
                               logic [FUNC_W-1:0] mode, logic last);
        lpb_in_t w;
        w.src_red    = r;
        w.src_green  = g;
        w.src_blue   = b;
        w.src_alpha  = a;
        w.func       = mode;
        w.last_layer = last;
        layer_q.push_back(w);
    endtask

    function automatic chan_t pick_chan();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return chan_t'(0);
        if (r == 1) return FULL_SCALE;
        return chan_t'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("layer_pixel_blender_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_layer(s_data);
            end
            if (!s_valid || s_ready) begin
                if ($urandom_range(0, 63) == 0) begin
                    send_calm = ~send_calm;
                end
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (layer_q.size() > 0) begin
                    s_data  <= layer_q.pop_front();
                    s_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        lpb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected output word %h", m_data);
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (m_data.out_red !== want.out_red ||
                            m_data.out_green !== want.out_green ||
                            m_data.out_blue !== want.out_blue ||
                            m_data.out_alpha !== want.out_alpha) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"expected r=%0d g=%0d b=%0d a=%0d, ",
                                      "got r=%0d g=%0d b=%0d a=%0d"},
                                     want.out_red, want.out_green, want.out_blue,
                                     want.out_alpha, m_data.out_red, m_data.out_green,
                                     m_data.out_blue, m_data.out_alpha);
                        end
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) begin
                recv_calm = ~recv_calm;
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap(recv_calm);
            end
        end
    end

    initial begin
        int sent;
        int layers;
        int i;
        int m;
        aresetn = 1'b0;

        queue_layer(8'd10, 8'd0, 8'd200, 8'd0, MODE_ADD, 1'b0);
        queue_layer(8'd20, 8'd0, 8'd55, 8'd0, MODE_ADD, 1'b1);
        queue_layer(8'd255, 8'd255, 8'd255, 8'd0, MODE_ADD, 1'b0);
        queue_layer(8'd255, 8'd1, 8'd128, 8'd0, MODE_ADD, 1'b1);
        queue_layer(8'd200, 8'd5, 8'd0, 8'd0, MODE_SRC, 1'b0);
        queue_layer(8'd50, 8'd10, 8'd0, 8'd0, MODE_SUB, 1'b1);
        queue_layer(8'd255, 8'd0, 8'd0, 8'd0, MODE_SUB, 1'b1);
        queue_layer(8'd255, 8'd128, 8'd1, 8'd0, MODE_SRC, 1'b0);
        queue_layer(8'd7, 8'd7, 8'd7, 8'd0, MODE_ZERO, 1'b1);
        queue_layer(8'd0, 8'd255, 8'd0, 8'd0, MODE_SRC, 1'b1);
        queue_layer(8'd255, 8'd0, 8'd100, 8'd0, MODE_SRC, 1'b0);
        queue_layer(8'd0, 8'd255, 8'd200, 8'd255, MODE_ALPHA_OVER, 1'b0);
        queue_layer(8'd128, 8'd64, 8'd1, 8'd0, MODE_ALPHA_OVER, 1'b0);
        queue_layer(8'd77, 8'd200, 8'd3, 8'd128, MODE_ALPHA_OVER, 1'b1);
        queue_layer(8'd90, 8'd180, 8'd45, 8'd0, MODE_SRC, 1'b0);
        for (m = MODE_ALPHA_OVER + 1; m < (1 << FUNC_W); m++) begin
            queue_layer(8'd255, 8'd255, 8'd255, 8'd255, m[FUNC_W-1:0],
                        m == (1 << FUNC_W) - 1);
        end
        queue_layer(8'd0, 8'd0, 8'd0, 8'd255, MODE_ALPHA_OVER, 1'b1);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            layers = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 12)
                                                  : $urandom_range(1, 6);
            for (i = 0; i < layers; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    m = $urandom_range(MODE_ALPHA_OVER + 1, (1 << FUNC_W) - 1);
                end else begin
                    m = $urandom_range(MODE_ADD, MODE_ALPHA_OVER);
                end
                queue_layer(pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                            m[FUNC_W-1:0], i == layers - 1);
            end
            sent += layers;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (layer_q.size() != 0 || s_valid || pixel_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("layer_pixel_blender_top: match");
        end else begin
            $display("layer_pixel_blender_top: mismatch");
        end
        $finish;
    end

endmodule
